[rtl/base64_decoder_macros.svh]
// assertion helpers for the base64 decoder
`ifndef BASE64_DECODER_MACROS_SVH
`define BASE64_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/b64d_pkg.sv]
`timescale 1ns / 1ps
package b64d_pkg;

  // input transaction: one encoded character
  typedef struct packed {
    logic [7:0] character;
    logic       new_buffer;
  } char_item_t;

  // output transaction: up to three decoded bytes
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] byte_count;
    logic       end_of_data;
    logic       truncated;
  } byte_item_t;

  // work passed from the classifier to the limiter
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] n;
    logic       ended;
    logic       clear;
  } job_t;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [6:0] SEXTET_PLUS  = 7'd62;
  localparam logic [6:0] SEXTET_SLASH = 7'd63;
  localparam logic [6:0] SEXTET_DIGIT = 7'd52;
  localparam logic [6:0] SEXTET_LOWER = 7'd26;
  localparam logic [6:0] SEXTET_NONE  = 7'd64;

  localparam logic [15:0] MAX_BYTES_RESET = 16'hFFFF;

  // standard alphabet lookup, SEXTET_NONE outside the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    case (c) inside
      [8'h41:8'h5A]: v = 7'(c - 8'h41);
      [8'h61:8'h7A]: v = 7'(c - 8'h61) + SEXTET_LOWER;
      [8'h30:8'h39]: v = 7'(c - 8'h30) + SEXTET_DIGIT;
      8'h2B:         v = SEXTET_PLUS;
      8'h2F:         v = SEXTET_SLASH;
      default:       v = SEXTET_NONE;
    endcase
    return v;
  endfunction

endpackage

[rtl/b64d_front.sv]
`timescale 1ns / 1ps
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  b64d_pkg::char_item_t char_item,
  output logic                job_valid,
  input  logic                job_ready,
  output b64d_pkg::job_t      job
);
  import b64d_pkg::*;

  logic [1:0]  group_phase;
  logic [17:0] sextet_acc;
  logic        past_leading_space;
  logic        buffer_ended;
  logic        pending_clear;

  logic [1:0]  group_phase_next;
  logic [17:0] sextet_acc_next;
  logic        past_leading_space_next;
  logic        buffer_ended_next;

  logic        accept;
  logic        produce;
  logic [6:0]  sextet;
  logic        is_blank;
  logic [1:0]  phase_eff;
  logic [17:0] acc_eff;
  logic        past_eff;
  logic        ended_eff;

  assign char_ready = job_ready;
  assign accept     = char_valid && char_ready;
  assign sextet     = sextet_of(char_item.character);
  assign is_blank   = (char_item.character == CHAR_SPACE) ||
                      (char_item.character == CHAR_TAB);

  // state as seen by this character, after an optional buffer restart
  always_comb begin
    phase_eff = char_item.new_buffer ? 2'd0 : group_phase;
    acc_eff   = char_item.new_buffer ? '0 : sextet_acc;
    past_eff  = char_item.new_buffer ? 1'b0 : past_leading_space;
    ended_eff = char_item.new_buffer ? 1'b0 : buffer_ended;
  end

  // classify the character and build the job for the back end
  always_comb begin
    group_phase_next        = phase_eff;
    sextet_acc_next         = acc_eff;
    past_leading_space_next = past_eff;
    buffer_ended_next       = ended_eff;
    produce                 = 1'b0;
    job                     = '0;
    job.clear               = char_item.new_buffer || pending_clear;
    if (!ended_eff && !(!past_eff && is_blank)) begin
      past_leading_space_next = 1'b1;
      if (sextet != SEXTET_NONE) begin
        if (phase_eff == 2'd3) begin
          produce         = 1'b1;
          job.b0          = acc_eff[17:10];
          job.b1          = {acc_eff[9:2]};
          job.b2          = {acc_eff[1:0], sextet[5:0]};
          job.n           = 2'd3;
          group_phase_next = 2'd0;
          sextet_acc_next  = '0;
        end else begin
          sextet_acc_next  = {acc_eff[11:0], sextet[5:0]};
          group_phase_next = phase_eff + 2'd1;
        end
      end else begin
        // terminator: flush pending sextets
        produce           = 1'b1;
        job.ended         = 1'b1;
        buffer_ended_next = 1'b1;
        group_phase_next  = 2'd0;
        sextet_acc_next   = '0;
        if (phase_eff == 2'd2) begin
          job.b0 = acc_eff[11:4];
          job.n  = 2'd1;
        end else if (phase_eff == 2'd3) begin
          job.b0 = acc_eff[17:10];
          job.b1 = acc_eff[9:2];
          job.n  = 2'd2;
        end
      end
    end
  end

  assign job_valid = char_valid && produce;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase        <= 2'd0;
      sextet_acc         <= '0;
      past_leading_space <= 1'b0;
      buffer_ended       <= 1'b0;
      pending_clear      <= 1'b0;
    end else if (accept) begin
      group_phase        <= group_phase_next;
      sextet_acc         <= sextet_acc_next;
      past_leading_space <= past_leading_space_next;
      buffer_ended       <= buffer_ended_next;
      // a restart that made no job still has to reach the byte counter
      if (produce) begin
        pending_clear <= 1'b0;
      end else if (char_item.new_buffer) begin
        pending_clear <= 1'b1;
      end
    end
  end

endmodule

[rtl/b64d_queue.sv]
`timescale 1ns / 1ps
module b64d_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  b64d_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output b64d_pkg::job_t pop_data
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/b64d_back.sv]
`timescale 1ns / 1ps
module b64d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  b64d_pkg::job_t       job,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output logic                 byte_valid,
  input  logic                 byte_ready,
  output b64d_pkg::byte_item_t byte_item
);
  import b64d_pkg::*;

  logic [15:0] max_output_bytes;
  logic [15:0] bytes_delivered;
  logic [15:0] bytes_delivered_next;
  logic [15:0] base;
  logic [15:0] room;
  logic [1:0]  keep;
  logic        take;
  byte_item_t  result;

  assign job_ready = !byte_valid || byte_ready;
  assign take      = job_valid && job_ready;

  // apply the per-buffer byte limit
  always_comb begin
    base = job.clear ? '0 : bytes_delivered;
    room = (base < max_output_bytes) ? (max_output_bytes - base) : '0;
    keep = (room < {14'd0, job.n}) ? room[1:0] : job.n;
    bytes_delivered_next   = base + {14'd0, keep};
    result.byte_first      = (keep > 2'd0) ? job.b0 : '0;
    result.byte_second     = (keep > 2'd1) ? job.b1 : '0;
    result.byte_third      = (keep > 2'd2) ? job.b2 : '0;
    result.byte_count      = keep;
    result.end_of_data     = job.ended;
    result.truncated       = (keep < job.n);
  end

  // config register and delivered count
  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= MAX_BYTES_RESET;
      bytes_delivered  <= '0;
    end else begin
      if (cfg_we) begin
        max_output_bytes <= cfg_wdata;
      end
      if (take) begin
        bytes_delivered <= bytes_delivered_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (take) begin
      byte_valid <= 1'b1;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_item <= result;
    end
  end

endmodule

[rtl/base64_decoder.sv]
`timescale 1ns / 1ps
// channel      | handshake               | payload
// character in | char_valid / char_ready | char_item (character, new_buffer)
// bytes out    | byte_valid / byte_ready | byte_item (three bytes, count, flags)
// config       | cfg_we                  | cfg_wdata (max_output_bytes)
//
// one character per cycle while char_ready is high; each result passes from its character
// through the classifier into the queue, then through the limiter into the output register
// the queue of QUEUE_DEPTH jobs absorbs output stalls; char_ready drops when it is full
// rst is synchronous: clears parse state, queue, byte count; limit returns to 65535
module base64_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  b64d_pkg::char_item_t char_item,
  output logic                 byte_valid,
  input  logic                 byte_ready,
  output b64d_pkg::byte_item_t byte_item,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);
  import b64d_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_data;
  logic q_valid;
  logic q_ready;
  job_t q_data;
  logic has_payload;

  // classifier
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .job_valid  (push_valid),
    .job_ready  (push_ready),
    .job        (push_data)
  );

  // decoupling queue
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // limiter and output register
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_ready  (q_ready),
    .job        (q_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
  );

  // result carries bytes, a drop or an end mark
  assign has_payload = (byte_item.byte_count != 2'd0) || byte_item.end_of_data ||
                       byte_item.truncated;

  `include "base64_decoder_macros.svh"

  // every result carries bytes, a drop or an end mark
  `B64D_ASSERT_NOW(a_result_nonempty, byte_valid, has_payload, "empty result transaction")
  // input only stalls while the queue holds work
  `B64D_ASSERT_NOW(a_stall_has_work, !char_ready, q_valid, "input stalled with empty queue")
  // an empty output register takes queued work at once
  `B64D_ASSERT_NEXT(a_back_drains, q_valid && !byte_valid, byte_valid, "queued job not taken")

endmodule
